### sv/dlr_pkg.sv
// Shared constants, types and codes for the DDA line rasterizer.
`timescale 1ns / 1ps

package dlr_pkg;

	localparam int COORD_BITS = 10;
	localparam int FRAC_BITS  = 16;

	// Accumulators hold a sign bit, the integer pixel part and the fraction.
	localparam int ACC_W     = COORD_BITS + FRAC_BITS + 1;
	// Increment magnitude never exceeds 1.0, so one integer bit plus sign.
	localparam int INC_W     = FRAC_BITS + 2;
	localparam int QUO_W     = FRAC_BITS + 1;
	localparam int NUM_W     = COORD_BITS + FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(NUM_W + 1);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_POINT = 2'd2
	} cmd_kind_t;

	// A classified item as it waits in the queue.
	typedef struct packed {
		cmd_kind_t kind;
		coord_t    x_start;
		coord_t    y_start;
		coord_t    x_end;
		coord_t    y_end;
		coord_t    adx;
		coord_t    ady;
		coord_t    steps;
		logic      neg_x;
		logic      neg_y;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [1:0] {
		BK_IDLE  = 2'd0,
		BK_DIV   = 2'd1,
		BK_START = 2'd2
	} back_state_t;

endpackage

### sv/dlr_front.sv
// Front end: accepts input items, works out deltas and step count, and classifies them.
`timescale 1ns / 1ps

module dlr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [dlr_pkg::IN_DATA_W-1:0] s_tdata,   // x_start, y_start, x_end, y_end
	input  logic                          s_tuser,   // mode
	output logic                          push,
	output dlr_pkg::cmd_t                 push_cmd,
	input  dlr_pkg::q_status_t            q_status
);

	logic            valid_s1;
	dlr_pkg::cmd_t   cmd_s1;
	dlr_pkg::cmd_t   cmd_d;
	dlr_pkg::coord_t xs, ys, xe, ye;
	logic            accept;

	assign xs = s_tdata[0*dlr_pkg::COORD_BITS +: dlr_pkg::COORD_BITS];
	assign ys = s_tdata[1*dlr_pkg::COORD_BITS +: dlr_pkg::COORD_BITS];
	assign xe = s_tdata[2*dlr_pkg::COORD_BITS +: dlr_pkg::COORD_BITS];
	assign ye = s_tdata[3*dlr_pkg::COORD_BITS +: dlr_pkg::COORD_BITS];

	assign push     = valid_s1 && !q_status.full;
	assign push_cmd = cmd_s1;
	assign s_tready = !valid_s1 || !q_status.full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd_d         = '0;
		cmd_d.x_start = xs;
		cmd_d.y_start = ys;
		cmd_d.x_end   = xe;
		cmd_d.y_end   = ye;
		cmd_d.neg_x   = xe < xs;
		cmd_d.neg_y   = ye < ys;
		cmd_d.adx     = cmd_d.neg_x ? xs - xe : xe - xs;
		cmd_d.ady     = cmd_d.neg_y ? ys - ye : ye - ys;
		cmd_d.steps   = (cmd_d.adx > cmd_d.ady) ? cmd_d.adx : cmd_d.ady;
		if (s_tuser == dlr_pkg::MODE_TICK) begin
			cmd_d.kind = dlr_pkg::CMD_TICK;
		end else if (cmd_d.steps == '0) begin
			cmd_d.kind = dlr_pkg::CMD_POINT;
		end else begin
			cmd_d.kind = dlr_pkg::CMD_LOAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

### sv/dlr_fifo.sv
// Short command queue between the front end and the stepping engine.
`timescale 1ns / 1ps

module dlr_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dlr_pkg::cmd_t      push_cmd,
	input  logic               pop,
	output dlr_pkg::cmd_t      pop_cmd,
	output dlr_pkg::q_status_t q_status
);

	dlr_pkg::cmd_t                  entries_q [dlr_pkg::FIFO_DEPTH];
	logic [dlr_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [dlr_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [dlr_pkg::FIFO_PTR_W:0]   count_q;
	logic                           do_push;
	logic                           do_pop;

	assign q_status.full  = count_q == (dlr_pkg::FIFO_PTR_W + 1)'(dlr_pkg::FIFO_DEPTH);
	assign q_status.empty = count_q == '0;
	assign pop_cmd        = entries_q[rd_ptr_q];
	assign do_push        = push && !q_status.full;
	assign do_pop         = pop && !q_status.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### sv/dlr_back.sv
// Stepping engine: serial increment divider, DDA accumulators and output register.
`timescale 1ns / 1ps

module dlr_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dlr_pkg::q_status_t             q_status,
	input  dlr_pkg::cmd_t                  pop_cmd,
	output logic                           pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [dlr_pkg::OUT_DATA_W-1:0] m_tdata,   // pixel_x, pixel_y
	output logic                           m_tuser,   // pixel_valid
	output logic                           m_tlast    // last_pixel
);

	localparam logic [dlr_pkg::FRAC_BITS-1:0] FRAC_HALF =
		{1'b1, {(dlr_pkg::FRAC_BITS-1){1'b0}}};
	localparam logic [dlr_pkg::DIV_CNT_W-1:0] DIV_LAST =
		dlr_pkg::DIV_CNT_W'(dlr_pkg::NUM_W - 1);

	dlr_pkg::back_state_t state_q, state_d;

	// Line state; the accumulators carry a built-in bias of one half pixel.
	logic                            active_q;
	logic [dlr_pkg::ACC_W-1:0]       x_acc_q, y_acc_q;
	logic [dlr_pkg::INC_W-1:0]       x_inc_q, y_inc_q;
	dlr_pkg::coord_t                 steps_left_q;
	dlr_pkg::coord_t                 x_tgt_q, y_tgt_q;

	// Divider state.
	dlr_pkg::cmd_t                   ld_q;
	logic [dlr_pkg::NUM_W-1:0]       num_x_q, num_y_q;
	dlr_pkg::coord_t                 rem_x_q, rem_y_q;
	logic [dlr_pkg::QUO_W-1:0]       quo_x_q, quo_y_q;
	logic [dlr_pkg::DIV_CNT_W-1:0]   div_cnt_q;

	// Output register.
	logic                            out_valid_q;
	logic                            out_pv_q;
	dlr_pkg::coord_t                 out_x_q, out_y_q;
	logic                            out_last_q;

	logic                            out_free;
	logic                            do_load, do_tick, do_point, do_start, emit;
	logic                            emit_pv, emit_last;
	dlr_pkg::coord_t                 emit_x, emit_y;
	logic [dlr_pkg::ACC_W-1:0]       x_acc_n, y_acc_n;
	dlr_pkg::coord_t                 steps_n;
	logic [dlr_pkg::COORD_BITS:0]    rem_sh_x, rem_sh_y;
	logic                            ge_x, ge_y;
	dlr_pkg::coord_t                 rem_nx, rem_ny;
	logic [dlr_pkg::INC_W-1:0]       quo_ext_x, quo_ext_y;

	assign out_free = !out_valid_q || m_tready;

	assign x_acc_n = x_acc_q + {{(dlr_pkg::ACC_W - dlr_pkg::INC_W){x_inc_q[dlr_pkg::INC_W-1]}},
		x_inc_q};
	assign y_acc_n = y_acc_q + {{(dlr_pkg::ACC_W - dlr_pkg::INC_W){y_inc_q[dlr_pkg::INC_W-1]}},
		y_inc_q};
	assign steps_n = steps_left_q - 1'b1;

	// One restoring division step per cycle on both axes, sharing the divisor.
	assign rem_sh_x = {rem_x_q, num_x_q[dlr_pkg::NUM_W-1]};
	assign rem_sh_y = {rem_y_q, num_y_q[dlr_pkg::NUM_W-1]};
	assign ge_x     = rem_sh_x >= {1'b0, ld_q.steps};
	assign ge_y     = rem_sh_y >= {1'b0, ld_q.steps};
	assign rem_nx   = dlr_pkg::COORD_BITS'(ge_x ? rem_sh_x - {1'b0, ld_q.steps} : rem_sh_x);
	assign rem_ny   = dlr_pkg::COORD_BITS'(ge_y ? rem_sh_y - {1'b0, ld_q.steps} : rem_sh_y);

	assign quo_ext_x = {1'b0, quo_x_q};
	assign quo_ext_y = {1'b0, quo_y_q};

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			dlr_pkg::BK_IDLE: begin
				if (!q_status.empty && pop_cmd.kind == dlr_pkg::CMD_LOAD) begin
					state_d = dlr_pkg::BK_DIV;
				end
			end
			dlr_pkg::BK_DIV: begin
				if (div_cnt_q == DIV_LAST) begin
					state_d = dlr_pkg::BK_START;
				end
			end
			dlr_pkg::BK_START: begin
				if (out_free) begin
					state_d = dlr_pkg::BK_IDLE;
				end
			end
			default: state_d = dlr_pkg::BK_IDLE;
		endcase
	end

	// Controls and the result to register.
	always_comb begin
		do_load   = 1'b0;
		do_tick   = 1'b0;
		do_point  = 1'b0;
		do_start  = 1'b0;
		emit_pv   = 1'b0;
		emit_x    = '0;
		emit_y    = '0;
		emit_last = 1'b0;
		case (state_q)
			dlr_pkg::BK_IDLE: begin
				if (!q_status.empty) begin
					case (pop_cmd.kind)
						dlr_pkg::CMD_LOAD:  do_load  = 1'b1;
						dlr_pkg::CMD_POINT: do_point = out_free;
						default:            do_tick  = out_free;
					endcase
				end
			end
			dlr_pkg::BK_START: do_start = out_free;
			default: ;
		endcase

		if (do_point) begin
			emit_pv   = 1'b1;
			emit_x    = pop_cmd.x_start;
			emit_y    = pop_cmd.y_start;
			emit_last = 1'b1;
		end else if (do_start) begin
			emit_pv = 1'b1;
			emit_x  = ld_q.x_start;
			emit_y  = ld_q.y_start;
		end else if (do_tick && active_q) begin
			emit_pv = 1'b1;
			if (steps_n == '0) begin
				emit_x    = x_tgt_q;
				emit_y    = y_tgt_q;
				emit_last = 1'b1;
			end else begin
				// A negative position saturates at column or row zero.
				emit_x = x_acc_n[dlr_pkg::ACC_W-1] ? '0 :
					x_acc_n[dlr_pkg::FRAC_BITS +: dlr_pkg::COORD_BITS];
				emit_y = y_acc_n[dlr_pkg::ACC_W-1] ? '0 :
					y_acc_n[dlr_pkg::FRAC_BITS +: dlr_pkg::COORD_BITS];
			end
		end
	end

	assign emit = do_point || do_start || do_tick;
	assign pop  = do_load || do_point || do_tick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= dlr_pkg::BK_IDLE;
			active_q     <= 1'b0;
			steps_left_q <= '0;
			out_valid_q  <= 1'b0;
			div_cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (do_load) begin
				div_cnt_q <= '0;
			end else if (state_q == dlr_pkg::BK_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (do_point) begin
				active_q     <= 1'b0;
				steps_left_q <= '0;
			end else if (do_start) begin
				active_q     <= 1'b1;
				steps_left_q <= ld_q.steps;
			end else if (do_tick && active_q) begin
				steps_left_q <= steps_n;
				if (steps_n == '0) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_pv_q   <= emit_pv;
			out_x_q    <= emit_x;
			out_y_q    <= emit_y;
			out_last_q <= emit_last;
		end
		if (do_load) begin
			ld_q    <= pop_cmd;
			num_x_q <= {pop_cmd.adx, {dlr_pkg::FRAC_BITS{1'b0}}};
			num_y_q <= {pop_cmd.ady, {dlr_pkg::FRAC_BITS{1'b0}}};
			rem_x_q <= '0;
			rem_y_q <= '0;
			quo_x_q <= '0;
			quo_y_q <= '0;
		end else if (state_q == dlr_pkg::BK_DIV) begin
			num_x_q <= num_x_q << 1;
			num_y_q <= num_y_q << 1;
			rem_x_q <= rem_nx;
			rem_y_q <= rem_ny;
			quo_x_q <= {quo_x_q[dlr_pkg::QUO_W-2:0], ge_x};
			quo_y_q <= {quo_y_q[dlr_pkg::QUO_W-2:0], ge_y};
		end
		if (do_start) begin
			x_inc_q <= ld_q.neg_x ? -quo_ext_x : quo_ext_x;
			y_inc_q <= ld_q.neg_y ? -quo_ext_y : quo_ext_y;
			x_acc_q <= {1'b0, ld_q.x_start, FRAC_HALF};
			y_acc_q <= {1'b0, ld_q.y_start, FRAC_HALF};
			x_tgt_q <= ld_q.x_end;
			y_tgt_q <= ld_q.y_end;
		end else if (do_tick && active_q) begin
			x_acc_q <= x_acc_n;
			y_acc_q <= y_acc_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_pv_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(dlr_pkg::OUT_DATA_W - 2*dlr_pkg::COORD_BITS){1'b0}}, out_y_q, out_x_q};

	a_no_pop_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dlr_pkg::BK_DIV |-> !pop)
		else $error("queue popped while the divider is busy");

	a_active_has_steps: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> steps_left_q != '0)
		else $error("active line with no steps left");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dlr_pkg::BK_DIV |-> (rem_x_q < ld_q.steps) && (rem_y_q < ld_q.steps))
		else $error("divider remainder out of range");

	a_idle_tick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0) && !m_tlast)
		else $error("empty result carries pixel data");

endmodule

### sv/dda_line_rasterizer_core.sv
// Top level of the DDA line rasterizer: front end, command queue and stepping engine.
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  tdata: x_start,y_start,x_end,y_end; tuser: mode
//  m_*       out        m_tvalid/m_tready  tdata: pixel_x,pixel_y; tuser: pixel_valid;
//                                          tlast: last_pixel
//
// Ticks and zero-length loads stream at one item per cycle while the output register is
// free; each passes the front register, a queue entry and then the output register.
// A line load is popped in BK_IDLE; the bit-serial divider then runs 26 iterations
// (COORD_BITS + FRAC_BITS) for both increments at once; then the start pixel is emitted.
// The front register and a four-entry queue keep taking items while the engine divides.
// arst_n clears all control state at once; there is no clearing pass.
// m_tready low holds the output register; the queue then fills and s_tready drops.
`timescale 1ns / 1ps

module dda_line_rasterizer_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [dlr_pkg::IN_DATA_W-1:0]  s_tdata,   // x_start, y_start, x_end, y_end
	input  logic                           s_tuser,   // mode
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [dlr_pkg::OUT_DATA_W-1:0] m_tdata,   // pixel_x, pixel_y
	output logic                           m_tuser,   // pixel_valid
	output logic                           m_tlast    // last_pixel
);

	logic               push;
	logic               pop;
	dlr_pkg::cmd_t      push_cmd;
	dlr_pkg::cmd_t      pop_cmd;
	dlr_pkg::q_status_t q_status;

	dlr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.push     (push),
		.push_cmd (push_cmd),
		.q_status (q_status)
	);

	dlr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.q_status (q_status)
	);

	dlr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.pop_cmd  (pop_cmd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### dv/testbench.sv
// Self-checking testbench for the DDA line rasterizer core with a pixel predictor.
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_HOLD = 400;
	localparam int TOTAL_ITEMS = 900;
	localparam int COORD_MAX = (1 << dlr_pkg::COORD_BITS) - 1;

	typedef struct {
		bit              valid;
		dlr_pkg::coord_t x;
		dlr_pkg::coord_t y;
		bit              last;
	} pixel_t;

	// Tracks the line state of the block and queues the pixel each item should produce.
	class raster_predictor;
		bit                               active;
		logic signed [dlr_pkg::ACC_W-1:0] x_acc;
		logic signed [dlr_pkg::ACC_W-1:0] y_acc;
		logic signed [dlr_pkg::INC_W-1:0] x_inc;
		logic signed [dlr_pkg::INC_W-1:0] y_inc;
		dlr_pkg::coord_t                  steps_left;
		dlr_pkg::coord_t                  x_goal;
		dlr_pkg::coord_t                  y_goal;
		pixel_t                           pending_pixels[$];
		int                               mismatches;

		function new();
			active = 0;
			x_acc = '0;
			y_acc = '0;
			x_inc = '0;
			y_inc = '0;
			steps_left = '0;
			x_goal = '0;
			y_goal = '0;
			mismatches = 0;
		endfunction

		// Per-step increment, truncated toward zero.
		function logic signed [dlr_pkg::INC_W-1:0] slope(int delta, int steps);
			longint q;
			q = (longint'(delta < 0 ? -delta : delta) << dlr_pkg::FRAC_BITS) / steps;
			return dlr_pkg::INC_W'(delta < 0 ? -q : q);
		endfunction

		// floor(acc + 0.5), held at zero below.
		function dlr_pkg::coord_t to_pixel(logic signed [dlr_pkg::ACC_W-1:0] acc);
			logic signed [dlr_pkg::ACC_W:0] s;
			s = acc;
			s = s + (dlr_pkg::ACC_W + 1)'(1 << (dlr_pkg::FRAC_BITS - 1));
			if (s < 0)
				return '0;
			return dlr_pkg::coord_t'(s >>> dlr_pkg::FRAC_BITS);
		endfunction

		function void take_command(logic mode, logic [dlr_pkg::IN_DATA_W-1:0] data);
			dlr_pkg::coord_t xs;
			dlr_pkg::coord_t ys;
			dlr_pkg::coord_t xe;
			dlr_pkg::coord_t ye;
			int              dx;
			int              dy;
			int              steps;
			pixel_t          p;
			xs = data[dlr_pkg::COORD_BITS-1:0];
			ys = data[2*dlr_pkg::COORD_BITS-1:dlr_pkg::COORD_BITS];
			xe = data[3*dlr_pkg::COORD_BITS-1:2*dlr_pkg::COORD_BITS];
			ye = data[4*dlr_pkg::COORD_BITS-1:3*dlr_pkg::COORD_BITS];
			if (mode == dlr_pkg::MODE_LOAD) begin
				dx = int'(xe) - int'(xs);
				dy = int'(ye) - int'(ys);
				steps = (dx < 0) ? -dx : dx;
				if ((dy < 0 ? -dy : dy) > steps)
					steps = (dy < 0) ? -dy : dy;
				if (steps == 0) begin
					active = 0;
					steps_left = '0;
					p = '{1'b1, xs, ys, 1'b1};
				end else begin
					x_inc = slope(dx, steps);
					y_inc = slope(dy, steps);
					x_acc = {1'b0, xs, {dlr_pkg::FRAC_BITS{1'b0}}};
					y_acc = {1'b0, ys, {dlr_pkg::FRAC_BITS{1'b0}}};
					steps_left = dlr_pkg::coord_t'(steps);
					x_goal = xe;
					y_goal = ye;
					active = 1;
					p = '{1'b1, xs, ys, 1'b0};
				end
			end else if (!active) begin
				p = '{1'b0, '0, '0, 1'b0};
			end else begin
				x_acc = x_acc + x_inc;
				y_acc = y_acc + y_inc;
				steps_left = steps_left - 1'b1;
				if (steps_left == 0) begin
					active = 0;
					p = '{1'b1, x_goal, y_goal, 1'b1};
				end else begin
					p = '{1'b1, to_pixel(x_acc), to_pixel(y_acc), 1'b0};
				end
			end
			pending_pixels.push_back(p);
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task compare_pixel(logic valid, logic [dlr_pkg::COORD_BITS-1:0] x,
				logic [dlr_pkg::COORD_BITS-1:0] y, logic last);
			pixel_t e;
			if (pending_pixels.size() == 0) begin
				report($sformatf("pixel with none expected: valid=%b x=%0d y=%0d last=%b",
					valid, x, y, last));
			end else begin
				e = pending_pixels.pop_front();
				if (valid !== e.valid || x !== e.x || y !== e.y || last !== e.last)
					report($sformatf("got valid=%b x=%0d y=%0d last=%b, want %b %0d %0d %b",
						valid, x, y, last, e.valid, e.x, e.y, e.last));
			end
		endtask
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [dlr_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                           s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [dlr_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           m_tuser;
	logic                           m_tlast;

	raster_predictor pred = new();
	bit     calm_tx;
	bit     calm_rx;
	int     items_sent;
	longint cycles;

	dda_line_rasterizer_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Both handshakes are sampled with the values they held just before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				pred.take_command(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				pred.compare_pixel(m_tuser, m_tdata[dlr_pkg::COORD_BITS-1:0],
					m_tdata[2*dlr_pkg::COORD_BITS-1:dlr_pkg::COORD_BITS], m_tlast);
		end
	end

	function dlr_pkg::coord_t to_coord(int v);
		return dlr_pkg::coord_t'(v);
	endfunction

	function dlr_pkg::coord_t rnd_coord();
		return dlr_pkg::coord_t'($urandom_range(0, COORD_MAX));
	endfunction

	task send_item(logic mode, dlr_pkg::coord_t xs, dlr_pkg::coord_t ys, dlr_pkg::coord_t xe,
			dlr_pkg::coord_t ye);
		int gap;
		gap = calm_tx ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {ye, xe, ys, xs};
		s_tuser <= mode;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	// Tick items carry random coordinates, which the block must ignore.
	task draw_line(dlr_pkg::coord_t xs, dlr_pkg::coord_t ys, dlr_pkg::coord_t xe,
			dlr_pkg::coord_t ye, int ticks);
		send_item(dlr_pkg::MODE_LOAD, xs, ys, xe, ye);
		repeat (ticks)
			send_item(dlr_pkg::MODE_TICK, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
	endtask

	function dlr_pkg::coord_t near(dlr_pkg::coord_t c, int span);
		int lo;
		int hi;
		lo = int'(c) - span;
		hi = int'(c) + span;
		if (lo < 0)
			lo = 0;
		if (hi > COORD_MAX)
			hi = COORD_MAX;
		return dlr_pkg::coord_t'($urandom_range(lo, hi));
	endfunction

	function int line_steps(dlr_pkg::coord_t xs, dlr_pkg::coord_t ys, dlr_pkg::coord_t xe,
			dlr_pkg::coord_t ye);
		int ax;
		int ay;
		ax = int'(xe) - int'(xs);
		ay = int'(ye) - int'(ys);
		if (ax < 0)
			ax = -ax;
		if (ay < 0)
			ay = -ay;
		return ax > ay ? ax : ay;
	endfunction

	// Receiver: random stalls per pixel, with one long hold so the queue backs up.
	initial begin
		int stall;
		int taken;
		taken = 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = calm_rx ? 0 : $urandom_range(0, 16);
			if (taken == 300)
				stall = LONG_HOLD;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			taken++;
		end
	end

	initial begin
		dlr_pkg::coord_t xs;
		dlr_pkg::coord_t ys;
		dlr_pkg::coord_t xe;
		dlr_pkg::coord_t ye;
		int              kind;
		int              steps;
		int              ticks;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		calm_tx = 0;
		calm_rx = 0;
		items_sent = 0;
		cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle tick, zero-length lines, all slope directions, run past the end,
		// and a new load dropping an active line.
		send_item(dlr_pkg::MODE_TICK, '1, '1, '1, '1);
		send_item(dlr_pkg::MODE_LOAD, '0, '0, '0, '0);
		send_item(dlr_pkg::MODE_TICK, '0, '0, '0, '0);
		send_item(dlr_pkg::MODE_LOAD, '1, '1, '1, '1);
		draw_line('0, '0, to_coord(3), to_coord(1), 4);
		draw_line('1, '0, to_coord(COORD_MAX - 3), to_coord(2), 3);
		draw_line(to_coord(5), '1, to_coord(7), to_coord(COORD_MAX - 5), 5);
		draw_line('0, '0, '1, '1, 2);
		draw_line('1, '1, '0, '0, 2);
		draw_line(to_coord(512), to_coord(511), to_coord(512), to_coord(511), 1);

		// The longest possible line, dropped after a few dozen pixels.
		draw_line('1, to_coord(17), '0, to_coord(700), 40);

		// A medium line walked to its end, with a fractional minor axis.
		draw_line(to_coord(300), to_coord(17), '0, to_coord(140), 301);

		while (items_sent < TOTAL_ITEMS) begin
			if ($urandom_range(0, 5) == 0)
				calm_tx = ~calm_tx;
			if ($urandom_range(0, 5) == 0)
				calm_rx = ~calm_rx;
			kind = $urandom_range(0, 99);
			xs = rnd_coord();
			ys = rnd_coord();
			if (kind < 8) begin
				send_item(dlr_pkg::MODE_TICK, xs, ys, rnd_coord(), rnd_coord());
			end else if (kind < 18) begin
				// Long line cut short by the next load.
				draw_line(xs, ys, rnd_coord(), rnd_coord(), int'($urandom_range(0, 30)));
			end else if (kind < 23) begin
				send_item(dlr_pkg::MODE_LOAD, xs, ys, xs, ys);
			end else begin
				xe = near(xs, 16);
				ye = near(ys, 16);
				steps = line_steps(xs, ys, xe, ye);
				if ($urandom_range(0, 99) < 15)
					ticks = $urandom_range(0, steps);
				else
					ticks = steps + $urandom_range(0, 2);
				draw_line(xs, ys, xe, ye, ticks);
			end
		end
		s_tvalid <= 1'b0;

		while (pred.pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pred.mismatches == 0 && pred.pending_pixels.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### files.f
sv/dlr_pkg.sv
sv/dlr_front.sv
sv/dlr_fifo.sv
sv/dlr_back.sv
sv/dda_line_rasterizer_core.sv
dv/testbench.sv
